// File: rtl/wec_pkg.sv
// Shared types and constants for the windowed event counter.
// No dependencies; imported by every module under rtl/.
package wec_pkg;

  localparam int DEPTH   = 10;                    // stored events
  localparam int CNT_W   = $clog2(DEPTH + 1);     // holds 0..DEPTH
  localparam int TS_W    = 32;
  localparam int THR_W   = TS_W + 1;              // signed threshold
  localparam int RC_W    = 4;                     // result field width
  localparam int RC_MAX  = (1 << RC_W) - 1;
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [0:0] {
    OP_RECORD = 1'b0,
    OP_CHECK  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [TS_W-1:0]         ts;
    logic signed [THR_W-1:0] thr;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/windowed_event_counter.sv
// Top level of the windowed event counter: front end, queue, event store.
// Depends on wec_pkg, wec_front, wec_queue, wec_back.
//
//  port group        dir  handshake            beat
//  start/in_*        in   start && !busy       op, timestamp, window
//  out_strobe/out_*  out  out_strobe (1 cycle) recent_count (checks only)
//
// One item is taken per cycle while busy is low. A check's count passes
// through the front register, queue, compare register and count
// register. busy rises only when the front register holds an item and the
// two-entry queue is full; the store drains one queue entry every cycle
// that the queue is not empty. Results cannot be held off. Reset (rst_n low,
// synchronous) empties the store count and queue; no clearing pass is needed.
module windowed_event_counter import wec_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [0:0]      in_op,
  input  logic [TS_W-1:0] in_timestamp,
  input  logic [TS_W-1:0] in_window,
  output logic            out_strobe,
  output logic [RC_W-1:0] out_recent_count
);

  q_stat_t q_stat;
  logic    push, pop;
  item_t   push_item, head;

  assign pop = !q_stat.empty;

  wec_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_timestamp (in_timestamp),
    .in_window    (in_window),
    .q_stat       (q_stat),
    .push         (push),
    .push_item    (push_item)
  );

  wec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  wec_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop              (pop),
    .head             (head),
    .out_strobe       (out_strobe),
    .out_recent_count (out_recent_count)
  );

  a_chk_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.op == OP_CHECK) |-> ##2 out_strobe)
    else $error("check left the queue without a result");

  a_result_has_chk: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(pop && head.op == OP_CHECK, 2))
    else $error("result without a check");

  a_busy_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (q_stat.full && !push))
    else $error("busy while the queue has room");

endmodule

// File: rtl/wec_front.sv
// Front end: takes commands, computes the check threshold, holds one item
// until the queue has room. Depends on wec_pkg.
module wec_front import wec_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [0:0]        in_op,
  input  logic [TS_W-1:0]   in_timestamp,
  input  logic [TS_W-1:0]   in_window,
  input  q_stat_t           q_stat,
  output logic              push,
  output item_t             push_item
);

  logic  hold_r, hold_nxt;
  item_t item_r, item_nxt;
  logic  accept;

  assign push   = hold_r && !q_stat.full;
  assign busy   = hold_r && q_stat.full;
  assign accept = start && !busy;

  always_comb begin
    hold_nxt = accept || (hold_r && !push);
    item_nxt = item_r;
    if (accept) begin
      item_nxt.op  = op_t'(in_op);
      item_nxt.ts  = in_timestamp;
      // negative when the window reaches back past time zero
      item_nxt.thr = $signed({1'b0, in_timestamp}) - $signed({1'b0, in_window});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign push_item = item_r;

endmodule

// File: rtl/wec_queue.sv
// Short FIFO between the front end and the event store.
// Depends on wec_pkg for item_t and the queue depth.
module wec_queue import wec_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   head,
  output q_stat_t stat
);

  item_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign stat.full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

// File: rtl/wec_back.sv
// Back end: event store as a shift line (newest at cell 0), parallel
// threshold compare, then run-length count. Depends on wec_pkg.
module wec_back import wec_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop,
  input  item_t           head,
  output logic            out_strobe,
  output logic [RC_W-1:0] out_recent_count
);

  logic [TS_W-1:0]  cell_r [DEPTH];
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [DEPTH-1:0] ge, ge_r;
  logic             cmp_vld_r;
  logic             strobe_r;
  logic [RC_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0] run;
  logic             is_rec, is_chk;

  assign is_rec = pop && (head.op == OP_RECORD);
  assign is_chk = pop && (head.op == OP_CHECK);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CNT_W'(i) < fill_r) && ($signed({1'b0, cell_r[i]}) >= head.thr);
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (is_rec && fill_r != CNT_W'(DEPTH)) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  // first failing cell from the newest end sets the count
  always_comb begin
    run = CNT_W'(DEPTH);
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!ge_r[i]) begin
        run = CNT_W'(i);
      end
    end
    if (32'(run) > RC_MAX) begin
      count_nxt = RC_W'(RC_MAX);
    end else begin
      count_nxt = RC_W'(run);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      cmp_vld_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      cmp_vld_r <= is_chk;
      strobe_r  <= cmp_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (is_rec) begin
      cell_r[0] <= head.ts;
      for (int i = 1; i < DEPTH; i++) begin
        cell_r[i] <= cell_r[i-1];
      end
    end
    if (is_chk) begin
      ge_r <= ge;
    end
    if (cmp_vld_r) begin
      count_r <= count_nxt;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_recent_count = count_r;

endmodule

// File: verif/tb_windowed_event_counter.sv
// Self-checking testbench for windowed_event_counter: directed and random record/check beats,
// with an in-bench model of the timestamp ring that predicts every recent_count.
// Depends on wec_pkg and the windowed_event_counter RTL.
module tb_windowed_event_counter;
  timeunit 1ns;
  timeprecision 1ps;
  import wec_pkg::*;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            start;
  logic            busy;
  logic [0:0]      in_op;
  logic [TS_W-1:0] in_timestamp;
  logic [TS_W-1:0] in_window;
  logic            out_strobe;
  logic [RC_W-1:0] out_recent_count;

  windowed_event_counter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_timestamp     (in_timestamp),
    .in_window        (in_window),
    .out_strobe       (out_strobe),
    .out_recent_count (out_recent_count)
  );

  always #5 clk = ~clk;

  // Model of the event store
  logic [TS_W-1:0] seen_stamps [DEPTH];
  int              ring_fill;
  int              ring_head;

  logic [RC_W-1:0] pending_counts [$];
  int              fail_count;
  bit              no_gaps;

  function automatic void log_event(logic [TS_W-1:0] ts);
    if (ring_fill > 0) ring_head = (ring_head + 1) % DEPTH;
    seen_stamps[ring_head] = ts;
    if (ring_fill < DEPTH) ring_fill++;
  endfunction

  function automatic logic [RC_W-1:0] count_recent(logic [TS_W-1:0] now_ts,
                                                   logic [TS_W-1:0] win);
    longint thr;
    int     slot;
    int     hits;
    int     i;
    thr  = longint'(now_ts) - longint'(win);
    slot = ring_head;
    hits = 0;
    for (i = 0; i < ring_fill; i++) begin
      if (longint'(seen_stamps[slot]) < thr) break;
      hits++;
      slot = (slot == 0) ? DEPTH - 1 : slot - 1;
    end
    return (hits > RC_MAX) ? RC_MAX[RC_W-1:0] : hits[RC_W-1:0];
  endfunction

  // Timestamp k entries back from the newest one
  function automatic logic [TS_W-1:0] stamp_back(int k);
    return seen_stamps[(ring_head - k + DEPTH) % DEPTH];
  endfunction

  // Drives one beat from a falling edge and holds it until the block takes it
  task automatic send_beat(op_t op, logic [TS_W-1:0] ts, logic [TS_W-1:0] win);
    int idle;
    idle = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    start        <= 1'b1;
    in_op        <= op;
    in_timestamp <= ts;
    in_window    <= win;
    do @(posedge clk); while (busy);
    if (op == OP_RECORD) log_event(ts);
    else pending_counts.push_back(count_recent(ts, win));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual recent_count=%0d",
                 $time, out_recent_count);
        fail_count++;
      end else begin
        if (out_recent_count !== pending_counts[0]) begin
          $display("%0t: recent_count mismatch, expected %0d, actual %0d",
                   $time, pending_counts[0], out_recent_count);
          fail_count++;
        end
        void'(pending_counts.pop_front());
      end
    end
  end

  task automatic test_empty_store();
    send_beat(OP_CHECK, '0, '0);
    send_beat(OP_CHECK, '1, '1);
    send_beat(OP_CHECK, '1, '0);
  endtask

  // Extreme stamps, equal-to-threshold entries, negative threshold
  task automatic test_window_edges();
    send_beat(OP_RECORD, '0, $urandom());
    send_beat(OP_RECORD, '1, $urandom());
    send_beat(OP_RECORD, 32'd100, $urandom());
    send_beat(OP_CHECK, 32'd100, '0);
    send_beat(OP_CHECK, 32'd100, 32'd100);
    send_beat(OP_CHECK, 32'd99, '0);
    send_beat(OP_CHECK, 32'd101, '0);
    send_beat(OP_CHECK, '0, '1);
  endtask

  // Overfill the ring so the oldest entries are dropped
  task automatic test_ring_wrap();
    int i;
    for (i = 0; i < DEPTH + 2; i++) send_beat(OP_RECORD, 32'd1000 + i, $urandom());
    send_beat(OP_CHECK, 32'd2000, 32'd1000);
    send_beat(OP_CHECK, 32'd1000 + DEPTH + 1, 32'd5);
  endtask

  task automatic test_random_traffic(int n_beats);
    logic [TS_W-1:0] now;
    logic [TS_W-1:0] ts;
    logic [TS_W-1:0] win;
    op_t             op;
    int              sent;
    int              burst;
    now  = $urandom_range(0, 1000);
    sent = 0;
    while (sent < n_beats) begin
      burst   = $urandom_range(20, 60);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        case ($urandom_range(0, 99)) inside
          [0:0]:   now = $urandom();
          [1:1]:   now = 32'hFFFF_FFC0;
          default: ;
        endcase
        if ($urandom_range(0, 99) < 15) begin
          // noise: anything the fields allow
          op  = op_t'($urandom_range(0, 1));
          ts  = $urandom();
          win = $urandom();
        end else if ($urandom_range(0, 1) == 0) begin
          op  = OP_RECORD;
          win = $urandom();
          case ($urandom_range(0, 19))
            0, 1:    ts = now - $urandom_range(1, 30);   // late arrival
            2:       ts = $urandom();
            default: begin
              now = now + $urandom_range(0, 12);
              ts  = now;
            end
          endcase
        end else begin
          op = OP_CHECK;
          ts = now + $urandom_range(0, 8);
          case ($urandom_range(0, 5))
            0: win = '0;
            1: win = $urandom_range(0, 64);
            2, 3: begin
              // land on, just inside or just outside a stored stamp
              if (ring_fill > 0)
                win = ts - stamp_back($urandom_range(0, ring_fill - 1)) - 1
                      + $urandom_range(0, 2);
              else
                win = $urandom_range(0, 64);
            end
            4: win = ts + $urandom_range(0, 3);
            default: win = $urandom();
          endcase
        end
        send_beat(op, ts, win);
        sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    int i;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_op        = OP_RECORD;
    in_timestamp = '0;
    in_window    = '0;
    ring_fill    = 0;
    ring_head    = 0;
    fail_count   = 0;
    no_gaps      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_store();
    test_window_edges();
    test_ring_wrap();
    test_random_traffic(1700);

    @(negedge clk);
    start <= 1'b0;
    for (i = 0; i < 64 && pending_counts.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_counts.size() != 0) begin
      $display("%0t: %0d results never arrived, expected recent_count=%0d, actual none",
               $time, pending_counts.size(), pending_counts[0]);
      fail_count++;
    end
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
